// File: hdl/block_dictionary_dedup_encoder_top_defines.svh
// Assertion macros shared by the dictionary encoder RTL.
`ifndef BLOCK_DICTIONARY_DEDUP_ENCODER_TOP_DEFINES_SVH
`define BLOCK_DICTIONARY_DEDUP_ENCODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BDD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdd: next-cycle check failed");

`endif

// File: hdl/bdd_pkg.sv
// Shared types and constants of the block dictionary encoder.
`default_nettype none

package bdd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int BLEN_W   = 6;

    localparam logic [BLEN_W-1:0] BLOCK_LEN_RESET = 6'd32;

    localparam logic [OPCODE_W-1:0] OP_BUILD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_MATCHED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Controls broadcast from the sequencer to every byte cell.
    typedef struct packed {
        logic load;   // a stream byte is taken in this cycle
        logic close;  // this byte closes the block, cells above it pad with zero
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/bdd_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module bdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/bdd_cell.sv
// One byte cell: holds one block byte, compares it with its RAM lane, extends the match chain.
`default_nettype none

module bdd_cell #(
    parameter int INDEX = 0,
    parameter int POS_W = 5,
    parameter int LEN_W = 6
) (
    input  wire logic                  clk,
    input  wire bdd_pkg::cell_ctl_t    ctl,
    input  wire logic [POS_W-1:0]      pos,
    input  wire logic [LEN_W-1:0]      len,
    input  wire logic [bdd_pkg::BYTE_W-1:0] data_byte,
    input  wire logic [bdd_pkg::BYTE_W-1:0] lane,
    input  wire logic                  chain_in,
    output logic                       chain_out,
    output logic [bdd_pkg::BYTE_W-1:0] byte_out
);

    logic [bdd_pkg::BYTE_W-1:0] byte_reg;
    logic [bdd_pkg::BYTE_W-1:0] byte_next;
    logic                       eq_reg;
    logic                       eq_next;
    logic                       sel;
    logic                       above;
    logic                       masked;

    assign sel    = (pos == POS_W'(INDEX));
    assign above  = (POS_W'(INDEX) > pos);
    assign masked = (LEN_W'(INDEX) >= len);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.load && sel)
        begin
            byte_next = data_byte;
        end
        else if (ctl.close && above)
        begin
            byte_next = '0;
        end
        // Bytes beyond the block length never take part in the compare.
        eq_next = masked || (lane == byte_reg);
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eq_reg   <= eq_next;
    end

    assign chain_out = chain_in & eq_reg;
    assign byte_out  = byte_reg;

endmodule

`default_nettype wire

// File: hdl/bdd_ctrl.sv
// Sequencer: byte position, dictionary fill, scan pipeline and result registers.
`default_nettype none

module bdd_ctrl #(
    parameter int DICT_ENTRIES    = 256,
    parameter int POS_W           = 5,
    parameter int LEN_W           = 6,
    parameter int IDX_W           = 8,
    parameter int CNT_W           = 9
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [bdd_pkg::OPCODE_W-1:0]   opcode,
    input  wire logic                           end_of_data,
    input  wire logic [LEN_W-1:0]               len,
    input  wire logic                           found,
    output logic                                busy,
    output bdd_pkg::cell_ctl_t                  ctl,
    output logic [POS_W-1:0]                    pos,
    output logic                                ram_we,
    output logic [IDX_W-1:0]                    ram_addr,
    output logic                                out_valid,
    output logic [IDX_W-1:0]                    out_idx,
    output logic [bdd_pkg::STATUS_W-1:0]        out_status,
    output logic [CNT_W-1:0]                    out_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;
    logic             build_reg, build_next;
    logic [IDX_W-1:0] idx1_reg, idx1_next;
    logic [IDX_W-1:0] idx2_reg, idx2_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [bdd_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic [LEN_W-1:0] pos_inc;
    logic             issue;

    assign pos_inc = LEN_W'(pos_reg) + LEN_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        hit_next        = hit_reg;
        build_next      = build_reg;
        idx1_next       = idx1_reg;
        idx2_next       = idx2_reg;
        hit_idx_next    = hit_idx_reg;
        out_valid_next  = 1'b0;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ctl             = '0;
        ram_we          = 1'b0;
        ram_addr        = issue_reg[IDX_W-1:0];
        issue           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode) inside
                        bdd_pkg::OP_BUILD, bdd_pkg::OP_ENCODE:
                        begin
                            ctl.load = 1'b1;
                            if (end_of_data || (pos_inc >= len))
                            begin
                                ctl.close  = 1'b1;
                                pos_next   = '0;
                                build_next = (opcode == bdd_pkg::OP_BUILD);
                                issue_next = '0;
                                v1_next    = 1'b0;
                                v2_next    = 1'b0;
                                hit_next   = 1'b0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                pos_next = pos_inc[POS_W-1:0];
                            end
                        end
                        bdd_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                            pos_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // One entry read per cycle; the RAM and cell registers precede each result.
                issue     = (issue_reg < used_reg);
                v1_next   = issue;
                idx1_next = issue_reg[IDX_W-1:0];
                v2_next   = v1_reg;
                idx2_next = idx1_reg;
                if (issue)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (v2_reg && found)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx2_reg;
                    state_next   = S_DONE;
                end
                else if (!issue && !v1_reg && !v2_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ram_addr       = used_reg[IDX_W-1:0];
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                out_count_next = used_reg;
                if (hit_reg)
                begin
                    out_status_next = bdd_pkg::ST_MATCHED;
                    out_idx_next    = hit_idx_reg;
                end
                else if (!build_reg)
                begin
                    out_status_next = bdd_pkg::ST_NOT_FOUND;
                    out_idx_next    = '0;
                end
                else if (used_reg < CNT_W'(DICT_ENTRIES))
                begin
                    ram_we          = 1'b1;
                    out_status_next = bdd_pkg::ST_ADDED;
                    out_idx_next    = used_reg[IDX_W-1:0];
                    used_next       = used_reg + CNT_W'(1);
                    out_count_next  = used_reg + CNT_W'(1);
                end
                else
                begin
                    out_status_next = bdd_pkg::ST_FULL;
                    out_idx_next    = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            used_reg      <= '0;
            issue_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        build_reg      <= build_next;
        idx1_reg       <= idx1_next;
        idx2_reg       <= idx2_next;
        hit_idx_reg    <= hit_idx_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign pos        = pos_reg;
    assign out_valid  = out_valid_reg;
    assign out_idx    = out_idx_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

// File: hdl/block_dictionary_dedup_encoder_top.sv
// Top level of the fixed-block deduplication dictionary encoder.
//
//  channel   ports                                    transfer when
//  --------  ---------------------------------------  ----------------------
//  command   start, busy, opcode, data_byte,          start high, busy low
//            end_of_data
//  result    done, match_index, status, entry_count   done high (one cycle)
//  config    cfg_we, cfg_data                         cfg_we high
//
// A byte that does not close a block, a clear and an ignored opcode leave busy low.
// A closing byte keeps busy high while the scan reads one dictionary RAM row per cycle
// until a hit or the last used entry has been compared, and through the result state.
// done pulses in the same cycle as busy falls; the receiver cannot stall it.
// Reset clears control state only; the dictionary RAM needs no clearing pass.
`default_nettype none

`include "block_dictionary_dedup_encoder_top_defines.svh"

module block_dictionary_dedup_encoder_top #(
    parameter int MAX_BLOCK_BYTES = 32,
    parameter int DICT_ENTRIES    = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [bdd_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [bdd_pkg::BYTE_W-1:0]       data_byte,
    input  wire logic                             end_of_data,
    output logic                                  done,
    output logic [bdd_pkg::INDEX_W-1:0]           match_index,
    output logic [bdd_pkg::STATUS_W-1:0]          status,
    output logic [bdd_pkg::COUNT_W-1:0]           entry_count,
    input  wire logic                             cfg_we,
    input  wire logic [bdd_pkg::BLEN_W-1:0]       cfg_data
);

    localparam int POS_W  = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int IDX_W  = $clog2(DICT_ENTRIES);
    localparam int CNT_W  = $clog2(DICT_ENTRIES + 1);
    localparam int ROW_W  = MAX_BLOCK_BYTES * bdd_pkg::BYTE_W;
    localparam int MI_W   = bdd_pkg::INDEX_W;
    localparam int EC_W   = bdd_pkg::COUNT_W;

    logic [bdd_pkg::BLEN_W-1:0]  block_len_reg;
    logic [LEN_W-1:0]            len;
    bdd_pkg::cell_ctl_t          ctl;
    logic [POS_W-1:0]            pos;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_addr;
    logic [ROW_W-1:0]            ram_wdata;
    logic [ROW_W-1:0]            ram_rdata;
    logic [MAX_BLOCK_BYTES:0]    chain;
    logic [IDX_W-1:0]            out_idx;
    logic [CNT_W-1:0]            out_count;
    logic                        miss_done;
    logic                        full_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg <= bdd_pkg::BLOCK_LEN_RESET;
        end
        else if (cfg_we)
        begin
            block_len_reg <= cfg_data;
        end
    end

    // Zero counts as one byte; anything above the buffer size is clipped to it.
    always_comb
    begin
        if (block_len_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (32'(block_len_reg) > MAX_BLOCK_BYTES)
        begin
            len = LEN_W'(MAX_BLOCK_BYTES);
        end
        else
        begin
            len = LEN_W'(block_len_reg);
        end
    end

    bdd_ctrl #(
        .DICT_ENTRIES    (DICT_ENTRIES),
        .POS_W           (POS_W),
        .LEN_W           (LEN_W),
        .IDX_W           (IDX_W),
        .CNT_W           (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .end_of_data (end_of_data),
        .len         (len),
        .found       (chain[MAX_BLOCK_BYTES]),
        .busy        (busy),
        .ctl         (ctl),
        .pos         (pos),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .out_valid   (done),
        .out_idx     (out_idx),
        .out_status  (status),
        .out_count   (out_count)
    );

    bdd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign chain[0] = 1'b1;

    for (genvar k = 0; k < MAX_BLOCK_BYTES; k++)
    begin : g_cell
        bdd_cell #(
            .INDEX (k),
            .POS_W (POS_W),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .pos       (pos),
            .len       (len),
            .data_byte (data_byte),
            .lane      (ram_rdata[k*bdd_pkg::BYTE_W +: bdd_pkg::BYTE_W]),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1]),
            .byte_out  (ram_wdata[k*bdd_pkg::BYTE_W +: bdd_pkg::BYTE_W])
        );
    end

    assign match_index = MI_W'(out_idx);
    assign entry_count = EC_W'(out_count);

    assign miss_done = done && ((status == bdd_pkg::ST_NOT_FOUND) ||
                                (status == bdd_pkg::ST_FULL));
    assign full_done = done && (status == bdd_pkg::ST_FULL);

    `BDD_ASSERT_SAME(a_done_when_idle, done, !busy)
    `BDD_ASSERT_NEXT(a_write_means_added, ram_we, done && (status == bdd_pkg::ST_ADDED))
    `BDD_ASSERT_SAME(a_miss_index_zero, miss_done, match_index == '0)
    `BDD_ASSERT_SAME(a_full_count, full_done, entry_count == EC_W'(DICT_ENTRIES))

endmodule

`default_nettype wire
